### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is asserted
`define SRS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("srs assertion failed");

// Same-cycle implication under reset
`define SRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`SRS_ASSERT(label, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication under reset
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	`SRS_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

### src/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Types and codes shared by the sparse row store and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	// Request codes; the unused code is served as a read
	typedef enum logic [1:0] {
		REQ_SET  = 2'd0,
		REQ_ADD  = 2'd1,
		REQ_READ = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_UNINIT = 2'd1,
		ST_BOUNDS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_IN_USE = 1'b0,
		REG_COLS_IN_USE = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SRS_IDLE,
		SRS_FILL,
		SRS_SCAN,
		SRS_HIT,
		SRS_MISS,
		SRS_DONE
	} srs_state_t;

endpackage

`default_nettype wire

### src/srs_match_add.sv
// ----------------------------------------------------------------------------
// srs_match_add
// Shared slot unit: column compare and Q16.16 saturating add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srs_match_add (
	input  wire logic [15:0]        slot_col,
	input  wire logic [15:0]        req_col,
	input  wire logic signed [31:0] acc,
	input  wire logic signed [31:0] opnd,
	output logic                    match,
	output logic signed [31:0]      sum
);

	logic signed [32:0] wide;

	assign match = (slot_col == req_col);

	// Exact sum in 33 bits, then clamp to the 32-bit range
	always_comb begin
		wide = {acc[31], acc} + {opnd[31], opnd};
		if (wide[32] != wide[31]) begin
			sum = wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sum = wide[31:0];
		end
	end

endmodule

`default_nettype wire

### src/sparse_row_store_insert_accumulate.sv
// ----------------------------------------------------------------------------
// sparse_row_store_insert_accumulate
// Sparse matrix held as rows of (column, value) slots; set, add and read.
// ----------------------------------------------------------------------------
// Each item is one request. On acceptance the row's fill count is read into
// a register, then the row's slots are compared against the column one per
// cycle through the single read port of the slot memory, stopping at the
// first match; a hit or miss state does the write-back and a done state
// hands the result to the output register once that register is free. The
// block takes one item at a time; it may take the next while a result still
// waits. Fill counts are cleared at reset through per-row valid flags, so
// there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sparse_row_store_insert_accumulate
	import srs_pkg::*;
#(
	parameter int MAX_ROWS  = 256,
	parameter int ROW_SLOTS = 8,
	parameter int MAX_COLS  = 65536
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// request channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            req_type,
	input  wire logic [7:0]            row,
	input  wire logic [15:0]           col,
	input  wire logic signed [31:0]    value,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [31:0]         read_value,
	output logic                       found,
	output logic [1:0]                 status
);

	// Only 256 rows are addressable through the row field
	localparam int ROWS_EFF = (MAX_ROWS < 256) ? MAX_ROWS : 256;
	localparam int RW       = $clog2(ROWS_EFF);
	localparam int SW       = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
	localparam int FW       = $clog2(ROW_SLOTS + 1);
	localparam int DEPTH    = ROWS_EFF * ROW_SLOTS;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [16:0] MAX_ROWS_L = 17'(MAX_ROWS);
	localparam logic [24:0] MAX_COLS_L = 25'(MAX_COLS);
	localparam logic [FW-1:0] SLOTS_L  = FW'(ROW_SLOTS);

	// Configuration registers
	logic [8:0]  rows_in_use_q;
	logic [16:0] cols_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= '0;
			cols_in_use_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == REG_ROWS_IN_USE) begin
				rows_in_use_q <= cfg_wdata[8:0];
			end else if (cfg_idx == REG_COLS_IN_USE) begin
				cols_in_use_q <= cfg_wdata;
			end
		end
	end

	// Storage
	logic [FW-1:0]          fill_mem [ROWS_EFF];
	logic [15:0]            col_mem  [DEPTH];
	logic signed [31:0]     val_mem  [DEPTH];
	logic [ROWS_EFF-1:0]    fill_vld_q;

	// Request and working registers
	srs_state_t         state_q, state_d;
	logic [1:0]         req_q;
	logic [7:0]         row_q;
	logic [15:0]        col_q;
	logic signed [31:0] val_q;
	logic [FW-1:0]      fill_rd_q;
	logic               fill_vld_rd_q;
	logic [SW-1:0]      k_q;
	logic [15:0]        slot_col_q;
	logic signed [31:0] slot_val_q;
	logic signed [31:0] res_val_q;
	logic               res_found_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic signed [31:0] out_val_q;
	logic               out_found_q;
	status_t            out_status_q;

	// Sequencer strobes
	logic               rd_en;
	logic [SW-1:0]      rd_slot;
	logic               wr_col_en;
	logic               wr_val_en;
	logic [SW-1:0]      wr_slot;
	logic signed [31:0] wr_val;
	logic               fill_wr;
	logic               res_ld;
	logic signed [31:0] res_val_d;
	logic               res_found_d;
	status_t            res_status_d;
	logic               out_ld;

	// Derived request facts
	logic [RW-1:0]  row_idx;
	logic [AW-1:0]  base;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic [FW-1:0]  fill;
	logic [16:0]    nrows;
	logic [24:0]    ncols;
	logic           row_bad;
	logic           col_bad;
	logic           is_read;
	logic           match;
	logic signed [31:0] sum;

	assign row_idx = row_q[RW-1:0];
	assign base    = AW'(row_idx) * AW'(ROW_SLOTS);
	assign rd_addr = base + AW'(rd_slot);
	assign wr_addr = base + AW'(wr_slot);
	assign fill    = fill_vld_rd_q ? fill_rd_q : '0;
	assign nrows   = ({8'd0, rows_in_use_q} < MAX_ROWS_L) ? {8'd0, rows_in_use_q} : MAX_ROWS_L;
	assign ncols   = ({8'd0, cols_in_use_q} < MAX_COLS_L) ? {8'd0, cols_in_use_q} : MAX_COLS_L;
	assign row_bad = ({9'd0, row_q} >= nrows);
	assign col_bad = ({9'd0, col_q} >= ncols);
	assign is_read = (req_q != REQ_SET) && (req_q != REQ_ADD);

	// Shared compare / accumulate unit
	srs_match_add u_unit (
		.slot_col (slot_col_q),
		.req_col  (col_q),
		.acc      (slot_val_q),
		.opnd     (val_q),
		.match    (match),
		.sum      (sum)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SRS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		rd_en        = 1'b0;
		rd_slot      = '0;
		wr_col_en    = 1'b0;
		wr_val_en    = 1'b0;
		wr_slot      = '0;
		wr_val       = val_q;
		fill_wr      = 1'b0;
		res_ld       = 1'b0;
		res_val_d    = '0;
		res_found_d  = 1'b0;
		res_status_d = ST_OK;
		out_ld       = 1'b0;
		case (state_q)
			SRS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = SRS_FILL;
				end
			end
			SRS_FILL: begin
				if (is_read && row_bad) begin
					res_ld       = 1'b1;
					res_status_d = ST_BOUNDS;
					state_d      = SRS_DONE;
				end else if (!is_read && (rows_in_use_q == '0)) begin
					res_ld       = 1'b1;
					res_status_d = ST_UNINIT;
					state_d      = SRS_DONE;
				end else if (!is_read && (row_bad || col_bad)) begin
					res_ld       = 1'b1;
					res_status_d = ST_BOUNDS;
					state_d      = SRS_DONE;
				end else if (fill == '0) begin
					state_d = SRS_MISS;
				end else begin
					rd_en   = 1'b1;
					rd_slot = '0;
					state_d = SRS_SCAN;
				end
			end
			SRS_SCAN: begin
				if (match) begin
					state_d = SRS_HIT;
				end else if ((FW'(k_q) + FW'(1)) == fill) begin
					state_d = SRS_MISS;
				end else begin
					rd_en   = 1'b1;
					rd_slot = k_q + SW'(1);
				end
			end
			SRS_HIT: begin
				res_ld      = 1'b1;
				res_found_d = 1'b1;
				if (is_read) begin
					res_val_d = slot_val_q;
				end else begin
					wr_val_en = 1'b1;
					wr_slot   = k_q;
					wr_val    = (req_q == REQ_SET) ? val_q : sum;
				end
				state_d = SRS_DONE;
			end
			SRS_MISS: begin
				res_ld = 1'b1;
				if (!is_read) begin
					if (fill >= SLOTS_L) begin
						res_status_d = ST_FULL;
					end else begin
						wr_col_en = 1'b1;
						wr_val_en = 1'b1;
						wr_slot   = SW'(fill);
						fill_wr   = 1'b1;
					end
				end
				state_d = SRS_DONE;
			end
			SRS_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_ld  = 1'b1;
					state_d = SRS_IDLE;
				end
			end
			default: begin
				state_d = SRS_IDLE;
			end
		endcase
	end

	// Request capture and fill count read
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q     <= req_type;
			row_q     <= row;
			col_q     <= col;
			val_q     <= value;
			fill_rd_q <= fill_mem[row[RW-1:0]];
		end
		if (fill_wr) begin
			fill_mem[row_idx] <= fill + FW'(1);
		end
	end

	// Per-row valid flags stand in for the cleared fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q    <= '0;
			fill_vld_rd_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				fill_vld_rd_q <= fill_vld_q[row[RW-1:0]];
			end
			if (fill_wr) begin
				fill_vld_q[row_idx] <= 1'b1;
			end
		end
	end

	// Slot memory: one registered read, one write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			slot_col_q <= col_mem[rd_addr];
			slot_val_q <= val_mem[rd_addr];
			k_q        <= rd_slot;
		end
		if (wr_col_en) begin
			col_mem[wr_addr] <= col_q;
		end
		if (wr_val_en) begin
			val_mem[wr_addr] <= wr_val;
		end
	end

	// Result held until the output register is free
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_val_q    <= res_val_d;
			res_found_q  <= res_found_d;
			res_status_q <= res_status_d;
		end
		if (out_ld) begin
			out_val_q    <= res_val_q;
			out_found_q  <= res_found_q;
			out_status_q <= res_status_q;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_val_q;
	assign found      = out_found_q;
	assign status     = out_status_q;

endmodule

`default_nettype wire

### src/srs_checker.sv
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks on the sparse row store, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srs_checker
	import srs_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] read_value,
	input wire logic               found,
	input wire logic [1:0]         status
);

	// A stalled result item holds its fields
	`SRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(found) && $stable(status))

	// One item at a time: the block is busy right after an accept
	`SRS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// An error status never reports a found column
	`SRS_ASSERT_IMPL(a_err_not_found, clk, arst_n, out_valid && (status != ST_OK), !found)

	// No column found means a zero value
	`SRS_ASSERT_IMPL(a_absent_zero, clk, arst_n, out_valid && !found, read_value == 32'sd0)

endmodule

bind sparse_row_store_insert_accumulate srs_checker u_srs_checker (.*);

`default_nettype wire

### bench/tb_sparse_row_store_insert_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_row_store_insert_accumulate
// Self-checking bench for the sparse row store: set, add and read requests.
// ----------------------------------------------------------------------------
// A directed table covers the uninitialised store, the index bounds, a full
// row, saturation at both ends, the unused request code and contents kept
// across register changes. Random phases follow, each with its own register
// setting. Most items hit a small pool of rows and columns so that rows fill
// up and entries are found again; the rest is noise over the whole field
// range. Every result is checked field by field against an in-bench model of
// the store, in order. Both handshakes are throttled in random bursts,
// except in the last phase.
// ----------------------------------------------------------------------------

module tb_sparse_row_store_insert_accumulate;
	import srs_pkg::*;

	localparam int ROW_COUNT       = 256;
	localparam int ROW_SLOTS       = 8;
	localparam int COL_COUNT       = 65536;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 125;

	// one result item
	typedef struct packed {
		logic [31:0] rv;
		logic        fnd;
		status_t     st;
	} outcome_t;

	// one row of the directed table: a register setting or a request
	typedef struct {
		bit          is_cfg;
		logic [16:0] cfg_rows;
		logic [16:0] cfg_cols;
		logic [1:0]  kind;
		logic [7:0]  r;
		logic [15:0] c;
		logic [31:0] v;
		bit          typed;
		outcome_t    out;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            req_type;
	logic [7:0]            row;
	logic [15:0]           col;
	logic signed [31:0]    value;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [31:0]    read_value;
	logic                  found;
	logic [1:0]            status;

	// model of the store
	logic [8:0]  held_rows;
	logic [16:0] held_cols;
	logic [3:0]  fill_count [ROW_COUNT];
	logic [15:0] slot_col   [ROW_COUNT][ROW_SLOTS];
	logic [31:0] slot_val   [ROW_COUNT][ROW_SLOTS];

	outcome_t  awaited_results [$];
	plan_row_t directed_plan [$];
	int        errors;
	int        send_idle_pct;
	bit        calm;

	sparse_row_store_insert_accumulate #(
		.MAX_ROWS (ROW_COUNT),
		.ROW_SLOTS(ROW_SLOTS),
		.MAX_COLS (COL_COUNT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.row       (row),
		.col       (col),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_value(read_value),
		.found     (found),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one request to the model store and returns its result
	function automatic outcome_t serve_request(input logic [1:0] kind, input logic [7:0] r,
			input logic [15:0] c, input logic [31:0] v);
		outcome_t           res;
		int                 nrows;
		int                 ncols;
		int                 hit;
		logic signed [32:0] sum;
		res   = '{rv: 32'd0, fnd: 1'b0, st: ST_OK};
		nrows = (held_rows > ROW_COUNT) ? ROW_COUNT : int'(held_rows);
		ncols = (held_cols > COL_COUNT) ? COL_COUNT : int'(held_cols);
		hit   = -1;
		for (int k = 0; k < int'(fill_count[r]); k++)
			if (hit < 0 && slot_col[r][k] == c)
				hit = k;
		// the unused code is served as a read; reads check the row bound only
		if (kind >= REQ_READ) begin
			if (r >= nrows) begin
				res.st = ST_BOUNDS;
			end else if (hit >= 0) begin
				res.fnd = 1'b1;
				res.rv  = slot_val[r][hit];
			end
		end else if (held_rows == 0) begin
			res.st = ST_UNINIT;
		end else if (r >= nrows || c >= ncols) begin
			res.st = ST_BOUNDS;
		end else if (hit >= 0) begin
			res.fnd = 1'b1;
			if (kind == REQ_SET) begin
				slot_val[r][hit] = v;
			end else begin
				// exact sum, then clamp to the raw word range
				sum = {slot_val[r][hit][31], slot_val[r][hit]} + {v[31], v};
				if (sum[32] != sum[31])
					slot_val[r][hit] = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				else
					slot_val[r][hit] = sum[31:0];
			end
		end else if (fill_count[r] >= ROW_SLOTS) begin
			res.st = ST_FULL;
		end else begin
			slot_col[r][fill_count[r]] = c;
			slot_val[r][fill_count[r]] = v;
			fill_count[r]              = fill_count[r] + 4'd1;
		end
		return res;
	endfunction

	function automatic void plan_req(input logic [1:0] kind, input logic [7:0] r,
			input logic [15:0] c, input logic [31:0] v);
		plan_row_t e;
		e.is_cfg = 1'b0;
		e.kind   = kind;
		e.r      = r;
		e.c      = c;
		e.v      = v;
		e.typed  = 1'b0;
		e.out    = '{rv: 32'd0, fnd: 1'b0, st: ST_OK};
		directed_plan.insert(directed_plan.size(), e);
	endfunction

	// request whose result is plain to see
	function automatic void plan_typed(input logic [1:0] kind, input logic [7:0] r,
			input logic [15:0] c, input logic [31:0] v, input logic [31:0] rv,
			input logic fnd, input status_t st);
		plan_req(kind, r, c, v);
		directed_plan[$].typed = 1'b1;
		directed_plan[$].out   = '{rv: rv, fnd: fnd, st: st};
	endfunction

	function automatic void plan_regs(input logic [16:0] rows_v, input logic [16:0] cols_v);
		plan_row_t e;
		e.is_cfg   = 1'b1;
		e.cfg_rows = rows_v;
		e.cfg_cols = cols_v;
		e.typed    = 1'b0;
		directed_plan.insert(directed_plan.size(), e);
	endfunction

	// Offers one item, waits for it to be taken and records its result
	task automatic issue_request(input logic [1:0] kind, input logic [7:0] r,
			input logic [15:0] c, input logic [31:0] v, input bit typed,
			input outcome_t typed_out);
		outcome_t predicted;
		in_valid <= 1'b1;
		req_type <= kind;
		row      <= r;
		col      <= c;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = serve_request(kind, r, c, v);
		if (typed)
			predicted = typed_out;
		awaited_results.insert(awaited_results.size(), predicted);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14))
				@(posedge clk);
		end
	endtask

	// Stop sending, let every result come back, then set both registers
	task automatic write_regs(input logic [16:0] rows_v, input logic [16:0] cols_v);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (ROW_SLOTS + 4)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_ROWS_IN_USE;
		cfg_wdata <= rows_v;
		@(posedge clk);
		held_rows = rows_v[8:0];
		cfg_idx   <= REG_COLS_IN_USE;
		cfg_wdata <= cols_v;
		@(posedge clk);
		held_cols = cols_v;
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result item with nothing expected: read_value %h found %b status %0d",
					read_value, found, status);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				if (read_value !== want.rv) begin
					$error("read_value: expected %h, got %h", want.rv, read_value);
					errors++;
				end
				if (found !== want.fnd) begin
					$error("found: expected %b, got %b", want.fnd, found);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
			end
		end
	end

	// Result side pacing: runs of ready with stall bursts between them
	initial begin
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14))
					@(posedge clk);
			end
		end
	end

	// Watchdog
	initial begin
		#5ms;
		$display("tb_sparse_row_store_insert_accumulate: done, errors");
		$finish;
	end

	// Stimulus
	initial begin
		logic [16:0] rows_v;
		logic [16:0] cols_v;
		logic [1:0]  kind_v;
		logic [7:0]  r_v;
		logic [15:0] c_v;
		logic [31:0] v_v;
		logic [7:0]  hot_rows [6];
		logic [15:0] hot_cols [12];
		int          nrows;
		int          ncols;
		int          pick;
		int          guard;
		outcome_t    none;

		errors        = 0;
		calm          = 1'b0;
		send_idle_pct = 30;
		none          = '{rv: 32'd0, fnd: 1'b0, st: ST_OK};
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_ROWS_IN_USE;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		req_type  <= REQ_SET;
		row       <= 8'd0;
		col       <= 16'd0;
		value     <= 32'sd0;
		held_rows = 9'd0;
		held_cols = 17'd0;
		for (int i = 0; i < ROW_COUNT; i++) begin
			fill_count[i] = 4'd0;
			for (int k = 0; k < ROW_SLOTS; k++) begin
				slot_col[i][k] = 16'd0;
				slot_val[i][k] = 32'd0;
			end
		end

		// directed table
		// nothing configured yet
		plan_typed(REQ_SET, 8'd0, 16'd0, 32'h0001_0000, 32'd0, 1'b0, ST_UNINIT);
		plan_typed(REQ_ADD, 8'd0, 16'd0, 32'h0001_0000, 32'd0, 1'b0, ST_UNINIT);
		plan_typed(REQ_READ, 8'd0, 16'd0, 32'd0, 32'd0, 1'b0, ST_BOUNDS);
		plan_typed(2'b11, 8'd0, 16'd0, 32'd0, 32'd0, 1'b0, ST_BOUNDS);
		// widest store, saturation at both ends in the far corner
		plan_regs(17'd256, 17'd65536);
		plan_typed(REQ_SET, 8'd255, 16'hFFFF, 32'h7FFF_FFFF, 32'd0, 1'b0, ST_OK);
		plan_typed(REQ_ADD, 8'd255, 16'hFFFF, 32'h0000_0001, 32'd0, 1'b1, ST_OK);
		plan_typed(REQ_READ, 8'd255, 16'hFFFF, 32'd0, 32'h7FFF_FFFF, 1'b1, ST_OK);
		plan_typed(REQ_ADD, 8'd255, 16'hFFFF, 32'h8000_0000, 32'd0, 1'b1, ST_OK);
		plan_typed(REQ_ADD, 8'd255, 16'hFFFF, 32'h8000_0000, 32'd0, 1'b1, ST_OK);
		plan_typed(2'b11, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, ST_OK);
		plan_typed(REQ_READ, 8'd255, 16'd0, 32'd0, 32'd0, 1'b0, ST_OK);
		// diagonal entry
		plan_typed(REQ_SET, 8'd3, 16'd3, 32'h0002_8000, 32'd0, 1'b0, ST_OK);
		// fill a row, then one more column
		for (int k = 0; k < ROW_SLOTS; k++)
			plan_req(REQ_SET, 8'd7, 16'(k), 32'($urandom));
		plan_typed(REQ_SET, 8'd7, 16'(ROW_SLOTS), 32'd1, 32'd0, 1'b0, ST_FULL);
		plan_req(REQ_ADD, 8'd7, 16'd3, 32'hFFFF_0000);
		plan_req(REQ_READ, 8'd7, 16'd3, 32'd0);
		// narrowest store; row 7 falls out of range but keeps its entries
		plan_regs(17'd1, 17'd1);
		plan_typed(REQ_SET, 8'd1, 16'd0, 32'd5, 32'd0, 1'b0, ST_BOUNDS);
		plan_typed(REQ_SET, 8'd0, 16'd1, 32'd5, 32'd0, 1'b0, ST_BOUNDS);
		plan_typed(REQ_READ, 8'd0, 16'd40000, 32'd0, 32'd0, 1'b0, ST_OK);
		plan_typed(REQ_READ, 8'd7, 16'd3, 32'd0, 32'd0, 1'b0, ST_BOUNDS);
		plan_typed(REQ_SET, 8'd0, 16'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, ST_OK);

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg) begin
				write_regs(directed_plan[i].cfg_rows, directed_plan[i].cfg_cols);
			end else begin
				issue_request(directed_plan[i].kind, directed_plan[i].r, directed_plan[i].c,
					directed_plan[i].v, directed_plan[i].typed, directed_plan[i].out);
				maybe_pause();
			end
		end

		// random phases, one register setting each
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0, 4, 7: begin
					rows_v = 17'd256;
					cols_v = 17'd65536;
				end
				1: begin
					rows_v = 17'd4;
					cols_v = 17'd16;
				end
				3: begin
					rows_v = 17'd0;
					cols_v = 17'($urandom_range(0, 65536));
				end
				5: begin
					rows_v = 17'd1;
					cols_v = 17'd1;
				end
				6: begin
					rows_v = 17'($urandom_range(2, 255));
					cols_v = 17'd65536;
				end
				default: begin
					rows_v = 17'($urandom_range(2, 255));
					cols_v = 17'($urandom_range(1, 65535));
				end
			endcase
			write_regs(rows_v, cols_v);
			nrows = int'(rows_v);
			ncols = int'(cols_v);

			// the last phase runs with no throttling at all
			calm = (ph == NUM_PHASES - 1);
			case ($urandom_range(0, 2))
				0:       send_idle_pct = 0;
				1:       send_idle_pct = 25;
				default: send_idle_pct = 60;
			endcase

			// small pool of rows and columns so that rows fill and entries recur
			foreach (hot_rows[i])
				hot_rows[i] = (nrows == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, nrows - 1));
			foreach (hot_cols[i])
				hot_cols[i] = (ncols == 0) ? 16'($urandom)
					: 16'($urandom_range(0, ncols - 1));

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 80) begin
					r_v  = hot_rows[$urandom_range(0, 5)];
					c_v  = hot_cols[$urandom_range(0, 11)];
					pick = $urandom_range(0, 99);
					kind_v = (pick < 35) ? REQ_SET : (pick < 70) ? REQ_ADD : REQ_READ;
				end else begin
					r_v    = 8'($urandom_range(0, 255));
					c_v    = 16'($urandom);
					kind_v = 2'($urandom_range(0, 3));
				end
				// values near the ends often enough to saturate
				case ($urandom_range(0, 7))
					0:       v_v = 32'h7FFF_FFFF;
					1:       v_v = 32'h8000_0000;
					2:       v_v = {($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000,
						16'($urandom)};
					default: v_v = 32'($urandom);
				endcase
				issue_request(kind_v, r_v, c_v, v_v, 1'b0, none);
				maybe_pause();
			end
		end

		// drain
		in_valid <= 1'b0;
		guard = 0;
		while (awaited_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4 * ROW_SLOTS)
			@(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d result items never arrived", awaited_results.size());
			errors++;
		end

		if (errors == 0)
			$display("tb_sparse_row_store_insert_accumulate: done, clean");
		else
			$display("tb_sparse_row_store_insert_accumulate: done, errors");
		$finish;
	end

endmodule
